// ===== hw/rtl/cle_pkg.sv =====
// cle_pkg: shared types and constants of the compacting list engine
`default_nettype none

package cle_pkg;

	localparam int CLE_DEPTH = 128;

	typedef enum logic [2:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_COUNT  = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_READ   = 3'd4
	} cle_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} cle_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_FINISH
	} cle_state_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic [6:0]         index;
	} cle_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [7:0]         match_count;
		logic [7:0]         fill;
	} cle_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cle_ram.sv =====
// cle_ram: entry store, one write port and one registered read port
`default_nettype none

module cle_ram #(
	parameter int DEPTH = 128
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [31:0]                wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [31:0]                rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/compacting_list_engine_top.sv =====
// compacting_list_engine_top: list of signed words with append, remove, count, clear and read
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid / req_ready | cmd, value, index (cle_req_t)
//  rsp     | out       | rsp_valid / rsp_ready | status, data, match_count, fill
//
//  one item is worked at a time; req_ready is high only while the sequencer is idle
//  add, clear, bad commands and out-of-range indexes go from exec to finish with no walk before rsp_valid
//  read: walks one entry; remove at index i walks entries i up to fill; count walks all entries, none when empty
//  the walk is set by the single ram read port and the pointer/limit compare, one entry a cycle
//  arst_n clears the fill count and control; entries are not cleared and never read above fill
//  a finished result sits in the output register, so the next item is taken while it waits

module compacting_list_engine_top #(
	parameter int DEPTH = cle_pkg::CLE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire cle_pkg::cle_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output cle_pkg::cle_rsp_t      rsp
);

	import cle_pkg::*;

	// address width, fill width (holds DEPTH itself), compare and output widths
	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > 7) ? FW : 7;
	localparam int XW = (FW > 8) ? FW : 8;

	cle_state_t  state_q, state_d;
	cle_req_t    req_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rd_ptr_q;
	logic [FW-1:0] lim_q;
	logic [FW-1:0] cnt_q;
	logic [AW-1:0] wr_addr_q;
	logic          pend_q;
	logic          cap_q;
	logic          first_q;
	logic [1:0]    status_q;
	logic signed [31:0] data_q;
	cle_rsp_t      rsp_q;
	logic          rsp_valid_q;

	// ram side
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	// sequencer strobes
	logic          accept;
	logic          full;
	logic          in_range;
	logic          issue_rd;
	logic          walk_we;
	logic          walk_done;
	logic          hit;
	logic          rsp_load;
	logic [XW-1:0] fill_x;
	logic [XW-1:0] cnt_x;

	cle_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue_rd),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign accept   = req_valid && req_ready;
	assign full     = (fill_q >= FW'(DEPTH));
	assign in_range = (CW'(req_q.index) < CW'(fill_q));

	// the shared compare: pointer against limit decides every walk step
	assign issue_rd  = (state_q == ST_WALK) && (rd_ptr_q < lim_q);
	assign walk_done = (state_q == ST_WALK) && !issue_rd && !pend_q;
	// data read in the previous cycle moves one place down during a remove
	assign walk_we   = (state_q == ST_WALK) && pend_q && !cap_q
		&& (req_q.cmd == CMD_REMOVE);
	assign hit       = pend_q && !cap_q && (ram_rdata == req_q.value);
	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);

	// single write port: append from exec, compaction from the walk
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_addr_q;
		ram_wdata = ram_rdata;
		if (walk_we) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_EXEC) && (req_q.cmd == CMD_ADD) && !full) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q[AW-1:0];
			ram_wdata = req_q.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (req_q.cmd)
					CMD_REMOVE, CMD_READ: begin
						state_d = in_range ? ST_WALK : ST_FINISH;
					end
					CMD_COUNT: begin
						state_d = ST_WALK;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_q      <= 1'b0;
			cap_q       <= 1'b0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EXEC) begin
				pend_q  <= 1'b0;
				first_q <= (req_q.cmd != CMD_COUNT);
				case (req_q.cmd)
					CMD_ADD: begin
						if (!full) begin
							fill_q <= fill_q + FW'(1);
						end
					end
					CMD_CLEAR: begin
						fill_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_WALK) begin
				pend_q <= issue_rd;
				if (issue_rd) begin
					cap_q   <= first_q;
					first_q <= 1'b0;
				end
				if (walk_done && (req_q.cmd == CMD_REMOVE)) begin
					fill_q <= fill_q - FW'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_EXEC) begin
			status_q <= STAT_OK;
			data_q   <= '0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			lim_q    <= fill_q;
			case (req_q.cmd)
				CMD_ADD: begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						data_q <= req_q.value;
					end
				end
				CMD_REMOVE: begin
					if (!in_range) begin
						status_q <= STAT_RANGE;
					end
					rd_ptr_q <= FW'(req_q.index);
				end
				CMD_READ: begin
					if (!in_range) begin
						status_q <= STAT_RANGE;
					end
					rd_ptr_q <= FW'(req_q.index);
					lim_q    <= FW'(req_q.index) + FW'(1);
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_WALK) begin
			if (issue_rd) begin
				rd_ptr_q  <= rd_ptr_q + FW'(1);
				wr_addr_q <= rd_ptr_q[AW-1:0] - AW'(1);
			end
			if (pend_q && cap_q) begin
				data_q <= ram_rdata;
			end
			if (hit && (req_q.cmd == CMD_COUNT)) begin
				cnt_q <= cnt_q + FW'(1);
			end
		end
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.data        <= data_q;
			rsp_q.match_count <= cnt_x[7:0];
			rsp_q.fill        <= fill_x[7:0];
		end
	end

	assign fill_x    = XW'(fill_q);
	assign cnt_x     = XW'(cnt_q);
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// the fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("fill count above capacity");

	// compaction writes stay inside the filled range
	a_walk_write: assert property (@(posedge clk) disable iff (!arst_n)
		walk_we |-> (FW'(wr_addr_q) < fill_q))
		else $error("compaction write outside filled range");

	// the walk pointer never runs past its limit
	a_walk_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (rd_ptr_q <= lim_q))
		else $error("walk pointer past limit");

	// a result is loaded only from the finish state, and the sequencer then goes idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (state_q == ST_IDLE) && rsp_valid_q)
		else $error("result load without return to idle");

endmodule

`default_nettype wire

// ===== sim/cle_list_checker.sv =====
// cle_list_checker: tracks list contents from accepted commands and compares every response
`default_nettype none

module cle_list_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_ready,
	input  wire cle_pkg::cle_req_t req,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_ready,
	input  wire cle_pkg::cle_rsp_t rsp,
	output int                     errors,
	output int                     outstanding,
	output int                     checked
);
	import cle_pkg::*;

	logic [31:0]  list_words [CLE_DEPTH];
	int unsigned  list_fill;
	cle_rsp_t     expected_rsp [$];
	cle_rsp_t     want;

	initial begin
		errors      = 0;
		outstanding = 0;
		checked     = 0;
		list_fill   = 0;
	end

	// applies one command to the tracked list and returns the response it must give
	function automatic cle_rsp_t list_response(cle_req_t r);
		cle_rsp_t    p;
		int unsigned idx;
		int unsigned i;
		p   = '0;
		idx = r.index;
		case (r.cmd)
			CMD_ADD: begin
				if (list_fill >= CLE_DEPTH) begin
					p.status = STAT_FULL;
				end else begin
					list_words[list_fill] = r.value;
					list_fill++;
					p.data = r.value;
				end
			end
			CMD_REMOVE: begin
				if (idx >= list_fill) begin
					p.status = STAT_RANGE;
				end else begin
					p.data = list_words[idx];
					for (i = idx; i + 1 < list_fill; i++)
						list_words[i] = list_words[i + 1];
					list_fill--;
				end
			end
			CMD_COUNT: begin
				for (i = 0; i < list_fill; i++)
					if (list_words[i] == r.value)
						p.match_count++;
			end
			CMD_CLEAR: begin
				list_fill = 0;
			end
			CMD_READ: begin
				if (idx >= list_fill)
					p.status = STAT_RANGE;
				else
					p.data = list_words[idx];
			end
			default: begin
			end
		endcase
		p.fill = 8'(list_fill);
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rsp.delete();
			list_fill   = 0;
			outstanding = 0;
		end else begin
			// response first: one leaving on this edge belongs to an earlier command
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response with no command waiting: status %0d data %0d",
						rsp.status, rsp.data);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.data !== want.data) begin
						$error("data: expected %0d, got %0d", want.data, rsp.data);
						errors++;
					end
					if (rsp.match_count !== want.match_count) begin
						$error("match_count: expected %0d, got %0d",
							want.match_count, rsp.match_count);
						errors++;
					end
					if (rsp.fill !== want.fill) begin
						$error("fill: expected %0d, got %0d", want.fill, rsp.fill);
						errors++;
					end
					checked++;
				end
			end
			if (req_valid && req_ready)
				expected_rsp.push_back(list_response(req));
			outstanding = expected_rsp.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: drives commands into the list engine and reports the verdict
`default_nettype none

module testbench;
	import cle_pkg::*;

	localparam int          ITEMS         = 1300;
	// first code above the defined commands; 5 to 7 must do nothing
	localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
	// longest walk is a count over a full list, plus margin
	localparam int          DRAIN_CYCLES  = 200;
	localparam int          WAIT_LIMIT    = 20000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      rsp_ready = 1'b0;
	cle_req_t  req       = '0;
	logic      req_ready;
	logic      rsp_valid;
	cle_rsp_t  rsp;

	int        errors;
	int        outstanding;
	int        checked;

	// stimulus-side bookkeeping: rough list length steers indexes and phases
	int          list_len     = 0;
	logic [31:0] last_added   = '0;
	bit          growing      = 1'b1;
	int          burst_left   = 0;
	int          full_hits    = 0;
	int          cmd_seen [8];
	int          stall_left   = 0;
	int          stall_mode   = 0;

	// clock: 10 units per period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	compacting_list_engine_top #(
		.DEPTH(CLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	cle_list_checker list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked)
	);

	// receiver: runs of always-ready, coin-flip ready, and long stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(3, 30) : $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0, 1: rsp_ready <= 1'b1;
			2: rsp_ready <= 1'($urandom_range(0, 1));
			default: rsp_ready <= (stall_left == 0);
		endcase
	end

	function automatic cle_req_t make_req(logic [2:0] cmd, logic [31:0] value, logic [6:0] index);
		cle_req_t r;
		r.cmd   = cmd;
		r.value = value;
		r.index = index;
		return r;
	endfunction

	// values lean toward extremes and a small cluster so counts find duplicates
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5, 6: return 32'($urandom_range(0, 7)) - 32'd3;
			default: return $urandom();
		endcase
	endfunction

	// index inside the filled part, weighted to both ends; any index when the list is empty
	function automatic logic [6:0] pick_index_in();
		if (list_len == 0)
			return 7'($urandom_range(0, CLE_DEPTH - 1));
		case ($urandom_range(0, 3))
			0: return 7'd0;
			1: return 7'(list_len - 1);
			default: return 7'($urandom_range(0, list_len - 1));
		endcase
	endfunction

	function automatic logic [6:0] pick_index_out();
		if (list_len >= CLE_DEPTH)
			return 7'($urandom_range(0, CLE_DEPTH - 1));
		return 7'($urandom_range(list_len, CLE_DEPTH - 1));
	endfunction

	// one random command; growing phases mostly append, shrinking ones mostly remove
	function automatic cle_req_t pick_random();
		int roll;
		int t_add, t_rem, t_read, t_count, t_clear, t_other;
		roll = $urandom_range(0, 999);
		if (growing) begin
			t_add = 600; t_rem = 680; t_read = 800; t_count = 930; t_clear = 930;
			t_other = 960;
		end else begin
			t_add = 100; t_rem = 650; t_read = 770; t_count = 900; t_clear = 910;
			t_other = 940;
		end
		if (roll < t_add)
			return make_req(CMD_ADD, pick_value(), 7'($urandom()));
		if (roll < t_rem)
			return make_req(CMD_REMOVE, $urandom(), pick_index_in());
		if (roll < t_read)
			return make_req(CMD_READ, $urandom(), pick_index_in());
		if (roll < t_count) begin
			// half the counts look for the value appended last
			if ($urandom_range(0, 1))
				return make_req(CMD_COUNT, last_added, 7'($urandom()));
			return make_req(CMD_COUNT, pick_value(), 7'($urandom()));
		end
		if (roll < t_clear)
			return make_req(CMD_CLEAR, $urandom(), 7'($urandom()));
		if (roll < t_other)
			return make_req(3'(CMD_UNUSED_LO + 3'($urandom_range(0, 2))), $urandom(),
				7'($urandom()));
		// out-of-range remove or read
		if ($urandom_range(0, 1))
			return make_req(CMD_REMOVE, $urandom(), pick_index_out());
		return make_req(CMD_READ, $urandom(), pick_index_out());
	endfunction

	// present one item at the falling edge, hold it until taken, then maybe pause
	task automatic send(input cle_req_t r);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		cmd_seen[r.cmd]++;
		case (r.cmd)
			CMD_ADD: begin
				if (list_len < CLE_DEPTH) begin
					list_len++;
					last_added = r.value;
					if (list_len == CLE_DEPTH)
						full_hits++;
				end
			end
			CMD_REMOVE: if (r.index < list_len) list_len--;
			CMD_CLEAR: list_len = 0;
			default: begin
			end
		endcase
		// sender works in bursts; between bursts valid drops for a while
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap        = $urandom_range(1, 15);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stimulus and verdict
	initial begin
		int wait_cycles;
		foreach (cmd_seen[k])
			cmd_seen[k] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty list, extremes, duplicates, compaction, bounds, unused codes, clear
		send(make_req(CMD_READ,   32'h0,        7'd0));
		send(make_req(CMD_REMOVE, 32'h0,        7'd127));
		send(make_req(CMD_COUNT,  32'h0,        7'd0));
		send(make_req(CMD_ADD,    32'h8000_0000, 7'd0));
		send(make_req(CMD_ADD,    32'h7FFF_FFFF, 7'd127));
		send(make_req(CMD_ADD,    32'h0,        7'd0));
		send(make_req(CMD_ADD,    32'hFFFF_FFFF, 7'd0));
		send(make_req(CMD_ADD,    32'hFFFF_FFFF, 7'd0));
		send(make_req(CMD_COUNT,  32'hFFFF_FFFF, 7'd0));
		send(make_req(CMD_READ,   32'h0,        7'd3));
		// removing the head shifts every later entry down
		send(make_req(CMD_REMOVE, 32'h0,        7'd0));
		send(make_req(CMD_READ,   32'h0,        7'd0));
		// remove the tail, then the same index is now past the end
		send(make_req(CMD_REMOVE, 32'h0,        7'd3));
		send(make_req(CMD_REMOVE, 32'h0,        7'd3));
		send(make_req(CMD_READ,   32'h0,        7'd127));
		send(make_req(CMD_UNUSED_LO,         32'hFFFF_FFFF, 7'd127));
		send(make_req(3'(CMD_UNUSED_LO + 1), 32'h5A5A_A5A5, 7'd0));
		send(make_req(3'(CMD_UNUSED_LO + 2), 32'h0,        7'd64));
		send(make_req(CMD_COUNT,  32'h8000_0000, 7'd0));
		send(make_req(CMD_CLEAR,  32'h0,        7'd0));
		send(make_req(CMD_READ,   32'h0,        7'd0));
		send(make_req(CMD_COUNT,  32'hFFFF_FFFF, 7'd0));
		send(make_req(CMD_ADD,    32'd12345,    7'd0));

		// random: alternate filling to capacity (with adds past full) and draining
		repeat (ITEMS) begin
			send(pick_random());
			if (growing && list_len == CLE_DEPTH && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			else if (!growing && list_len == 0)
				growing = 1'b1;
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// let every response come back, then a margin for a stray one
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < WAIT_LIMIT) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("commands: add %0d, remove %0d, count %0d, clear %0d, read %0d, unused %0d",
			cmd_seen[CMD_ADD], cmd_seen[CMD_REMOVE], cmd_seen[CMD_COUNT],
			cmd_seen[CMD_CLEAR], cmd_seen[CMD_READ],
			cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
		$display("list filled to capacity %0d times; %0d responses compared",
			full_hits, checked);
		if (errors == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/cle_pkg.sv
hw/rtl/cle_ram.sv
hw/rtl/compacting_list_engine_top.sv
sim/cle_list_checker.sv
sim/testbench.sv
